[rtl/uvs_pkg.sv]
// Shared types, constants and helper functions of the UV sphere mesh generator.
package uvs_pkg;

  localparam int MAX_STACKS_DEF   = 255;
  localparam int MAX_SECTORS_DEF  = 255;
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;

  localparam logic signed [32:0] GAIN_Q30 = 33'sd652032874;
  localparam logic signed [32:0] ONE_Q30  = 33'sd1073741824;
  localparam logic signed [32:0] HALF32   = 33'sd2147483647 + 33'sd1;

  typedef enum logic [1:0] {
    KIND_VERT = 2'd0,
    KIND_TRI  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_STACK_COUNT  = 3'd0,
    REG_SECTOR_COUNT = 3'd1,
    REG_RADIUS       = 3'd2,
    REG_CENTER_X     = 3'd3,
    REG_CENTER_Y     = 3'd4,
    REG_CENTER_Z     = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_VERT,
    PH_UP,
    PH_LOW
  } phase_t;

  typedef struct packed {
    logic        valid;
    logic        err;
    logic        up;
    logic        low;
    logic [15:0] k1;
    logic [15:0] k2;
  } side_t;

  typedef struct packed {
    logic              flip;
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
  } rot_t;

  function automatic logic [31:0] atan_turn(input int k);
    logic [31:0] v;
    case (k)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic rot_t cordic_step(input rot_t r, input int k);
    rot_t o;
    logic signed [32:0] at;
    at = $signed({1'b0, atan_turn(k)});
    o = r;
    if (!r.z[32]) begin
      o.x = r.x - (r.y >>> k);
      o.y = r.y + (r.x >>> k);
      o.z = r.z - at;
    end else begin
      o.x = r.x + (r.y >>> k);
      o.y = r.y - (r.x >>> k);
      o.z = r.z + at;
    end
    return o;
  endfunction

  function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
    logic signed [31:0] o;
    if (v > 35'sd2147483647) o = 32'sh7FFFFFFF;
    else if (v < -35'sd2147483648) o = 32'sh80000000;
    else o = v[31:0];
    return o;
  endfunction

endpackage

[rtl/uvs_div_cell.sv]
// One restoring division cell that settles one quotient bit of both angles.
module uvs_div_cell
  import uvs_pkg::*;
#(
  parameter int NW  = 26,
  parameter int QW  = 17,
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  side_t         side_in,
  input  logic [NW-1:0] rl_in,
  input  logic [NW-1:0] rn_in,
  input  logic [QW-1:0] ql_in,
  input  logic [QW-1:0] qn_in,
  input  logic [8:0]    dl,
  input  logic [8:0]    dn,
  output side_t         side_out,
  output logic [NW-1:0] rl_out,
  output logic [NW-1:0] rn_out,
  output logic [QW-1:0] ql_out,
  output logic [QW-1:0] qn_out
);

  logic [NW-1:0] sh_l, sh_n;
  logic          ge_l, ge_n;
  logic [QW-1:0] ql_next, qn_next;

  always_comb begin
    sh_l = {{(NW-9){1'b0}}, dl} << BIT;
    sh_n = {{(NW-9){1'b0}}, dn} << BIT;
    ge_l = rl_in >= sh_l;
    ge_n = rn_in >= sh_n;
    ql_next = ql_in;
    qn_next = qn_in;
    ql_next[BIT] = ge_l;
    qn_next[BIT] = ge_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else if (en) begin
      side_out <= side_in;
    end
    if (en) begin
      rl_out <= ge_l ? rl_in - sh_l : rl_in;
      rn_out <= ge_n ? rn_in - sh_n : rn_in;
      ql_out <= ql_next;
      qn_out <= qn_next;
    end
  end

endmodule

[rtl/uvs_cordic_cell.sv]
// One CORDIC rotation cell that turns the latitude and longitude vectors by one step.
module uvs_cordic_cell
  import uvs_pkg::*;
#(
  parameter int K = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  side_t side_in,
  input  rot_t  a_in,
  input  rot_t  b_in,
  output side_t side_out,
  output rot_t  a_out,
  output rot_t  b_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else if (en) begin
      side_out <= side_in;
    end
    if (en) begin
      a_out <= cordic_step(a_in, K);
      b_out <= cordic_step(b_in, K);
    end
  end

endmodule

[rtl/uvs_emit.sv]
// Result serializer that turns one finished grid point into its vertex and triangle words, or an error word.
module uvs_emit
  import uvs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  side_t              side_in,
  input  logic signed [31:0] px_in,
  input  logic signed [31:0] py_in,
  input  logic signed [31:0] pz_in,
  input  logic signed [15:0] nx_in,
  input  logic signed [15:0] ny_in,
  input  logic signed [15:0] nz_in,
  output logic               take,
  output logic               busy,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [1:0]         kind,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [15:0] norm_x,
  output logic signed [15:0] norm_y,
  output logic signed [15:0] norm_z,
  output logic [15:0]        corner_a,
  output logic [15:0]        corner_b,
  output logic [15:0]        corner_c,
  output logic               last
);

  side_t              b_side;
  logic signed [31:0] b_px, b_py, b_pz;
  logic signed [15:0] b_nx, b_ny, b_nz;
  phase_t             phase, phase_next;
  logic               done, out_free, fire;

  kind_t              r_kind;
  logic signed [31:0] r_px, r_py, r_pz;
  logic signed [15:0] r_nx, r_ny, r_nz;
  logic [15:0]        r_a, r_b, r_c;

  assign out_free = !out_valid || !out_stall;
  assign fire     = b_side.valid && out_free;
  assign take     = !b_side.valid || (fire && done);
  assign busy     = b_side.valid && !done;

  always_comb begin
    phase_next = phase;
    done       = 1'b0;
    unique case (phase)
      PH_VERT: begin
        if (b_side.err || (!b_side.up && !b_side.low)) done = 1'b1;
        else phase_next = b_side.up ? PH_UP : PH_LOW;
      end
      PH_UP: begin
        if (b_side.low) phase_next = PH_LOW;
        else done = 1'b1;
      end
      PH_LOW: done = 1'b1;
      default: done = 1'b1;
    endcase
  end

  always_comb begin
    r_kind = KIND_TRI;
    r_px = '0;
    r_py = '0;
    r_pz = '0;
    r_nx = '0;
    r_ny = '0;
    r_nz = '0;
    r_a  = '0;
    r_b  = '0;
    r_c  = '0;
    unique case (phase)
      PH_VERT: begin
        if (b_side.err) begin
          r_kind = KIND_ERR;
        end else begin
          r_kind = KIND_VERT;
          r_px = b_px;
          r_py = b_py;
          r_pz = b_pz;
          r_nx = b_nx;
          r_ny = b_ny;
          r_nz = b_nz;
        end
      end
      PH_UP: begin
        r_a = b_side.k1;
        r_b = b_side.k2;
        r_c = b_side.k1 + 16'd1;
      end
      PH_LOW: begin
        r_a = b_side.k1 + 16'd1;
        r_b = b_side.k2;
        r_c = b_side.k2 + 16'd1;
      end
      default: r_kind = KIND_ERR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_side.valid <= 1'b0;
      phase        <= PH_VERT;
      out_valid    <= 1'b0;
    end else begin
      if (take) begin
        b_side <= side_in;
        phase  <= PH_VERT;
      end else if (fire) begin
        phase <= phase_next;
      end
      if (fire) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
    if (take) begin
      b_px <= px_in;
      b_py <= py_in;
      b_pz <= pz_in;
      b_nx <= nx_in;
      b_ny <= ny_in;
      b_nz <= nz_in;
    end
    if (fire) begin
      kind     <= r_kind;
      pos_x    <= r_px;
      pos_y    <= r_py;
      pos_z    <= r_pz;
      norm_x   <= r_nx;
      norm_y   <= r_ny;
      norm_z   <= r_nz;
      corner_a <= r_a;
      corner_b <= r_b;
      corner_c <= r_c;
      last     <= done;
    end
  end

endmodule

[rtl/uv_sphere_mesh_generator.sv]
// Top level of the UV sphere mesh generator: config registers, cell chains and result stages.
// Each grid point enters a pipeline of an input register, ANGLE_BITS+1 division cells, a fold
// stage, one CORDIC cell per iteration (at most 24), a clamp stage, two multiply stages, the
// serializer buffer and the output register. The output port carries one word per cycle
// while out_stall is low; a point yields only its vertex (or an error word), or its vertex
// followed by one or two triangle words; the pipeline stalls as a whole while the output
// serializer still holds words of an earlier point.
module uv_sphere_mesh_generator
  import uvs_pkg::*;
#(
  parameter int MAX_STACKS   = MAX_STACKS_DEF,
  parameter int MAX_SECTORS  = MAX_SECTORS_DEF,
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         stack_index,
  input  logic [7:0]         sector_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [15:0] norm_x,
  output logic signed [15:0] norm_y,
  output logic signed [15:0] norm_z,
  output logic [15:0]        corner_a,
  output logic [15:0]        corner_b,
  output logic [15:0]        corner_c,
  output logic               last
);

  localparam int NW = ANGLE_BITS + 10;
  localparam int QW = ANGLE_BITS + 1;
  localparam int NC = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam logic signed [63:0] RND29 = 64'sd536870912;
  localparam logic signed [64:0] RND29W = 65'sd536870912;
  localparam logic signed [63:0] RND45 = 64'sd35184372088832;

  logic [7:0]         stack_count, sector_count;
  logic [30:0]        sphere_radius;
  logic signed [31:0] center_x, center_y, center_z;
  logic [7:0]         sc, cc;
  logic               en, take, busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count   <= 8'd18;
      sector_count  <= 8'd36;
      sphere_radius <= 31'd65536;
      center_x      <= '0;
      center_y      <= '0;
      center_z      <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_STACK_COUNT:  stack_count   <= cfg_data[7:0];
        REG_SECTOR_COUNT: sector_count  <= cfg_data[7:0];
        REG_RADIUS:       sphere_radius <= cfg_data[30:0];
        REG_CENTER_X:     center_x      <= cfg_data;
        REG_CENTER_Y:     center_y      <= cfg_data;
        REG_CENTER_Z:     center_z      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (stack_count == 8'd0) sc = 8'd1;
    else if (32'(stack_count) > MAX_STACKS) sc = 8'(MAX_STACKS);
    else sc = stack_count;
    if (sector_count == 8'd0) cc = 8'd1;
    else if (32'(sector_count) > MAX_SECTORS) cc = 8'(MAX_SECTORS);
    else cc = sector_count;
  end

  assign en       = take;
  assign in_stall = !en;

  side_t       in_side, s0_side;
  logic [7:0]  s0_i, s0_j;
  logic [15:0] k1_full;

  always_comb begin
    k1_full       = {8'd0, stack_index} * ({8'd0, cc} + 16'd1) + {8'd0, sector_index};
    in_side.valid = in_valid;
    in_side.err   = (stack_index > sc) || (sector_index > cc);
    in_side.up    = !in_side.err && stack_index < sc && sector_index < cc
                    && stack_index != 8'd0;
    in_side.low   = !in_side.err && stack_index < sc && sector_index < cc
                    && stack_index != sc - 8'd1;
    in_side.k1    = k1_full;
    in_side.k2    = k1_full + {8'd0, cc} + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_side.valid <= 1'b0;
    end else if (en) begin
      s0_side <= in_side;
    end
    if (en) begin
      s0_i <= stack_index;
      s0_j <= sector_index;
    end
  end

  side_t         d_side [QW+1];
  logic [NW-1:0] d_rl [QW+1];
  logic [NW-1:0] d_rn [QW+1];
  logic [QW-1:0] d_ql [QW+1];
  logic [QW-1:0] d_qn [QW+1];

  assign d_side[0] = s0_side;
  assign d_rl[0]   = ({{(NW-8){1'b0}}, s0_i} << ANGLE_BITS) + {{(NW-8){1'b0}}, sc};
  assign d_rn[0]   = ({{(NW-8){1'b0}}, s0_j} << (ANGLE_BITS + 1)) + {{(NW-8){1'b0}}, cc};
  assign d_ql[0]   = '0;
  assign d_qn[0]   = '0;

  for (genvar g = 0; g < QW; g++) begin : g_div
    uvs_div_cell #(.NW(NW), .QW(QW), .BIT(QW - 1 - g)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .side_in(d_side[g]), .rl_in(d_rl[g]), .rn_in(d_rn[g]),
      .ql_in(d_ql[g]), .qn_in(d_qn[g]),
      .dl({sc, 1'b0}), .dn({cc, 1'b0}),
      .side_out(d_side[g+1]), .rl_out(d_rl[g+1]), .rn_out(d_rn[g+1]),
      .ql_out(d_ql[g+1]), .qn_out(d_qn[g+1])
    );
  end

  logic [QW-1:0]         lat_q;
  logic [ANGLE_BITS-1:0] lat, lon;
  rot_t                  fa, fb;
  side_t                 c_side [NC+1];
  rot_t                  c_a [NC+1];
  rot_t                  c_b [NC+1];

  function automatic rot_t fold(input logic [ANGLE_BITS-1:0] ang);
    rot_t r;
    logic [31:0] u;
    logic signed [32:0] z;
    u = {ang, {(32 - ANGLE_BITS){1'b0}}};
    z = $signed({u[31], u});
    r.flip = 1'b0;
    r.x = GAIN_Q30;
    r.y = '0;
    if (z > ONE_Q30) begin
      r.z = z - HALF32;
      r.flip = 1'b1;
    end else if (z < -ONE_Q30) begin
      r.z = z + HALF32;
      r.flip = 1'b1;
    end else begin
      r.z = z;
    end
    return r;
  endfunction

  always_comb begin
    lat_q = QW'(1 << (ANGLE_BITS - 2)) - d_ql[QW];
    lat   = lat_q[ANGLE_BITS-1:0];
    lon   = d_qn[QW][ANGLE_BITS-1:0];
    fa    = fold(lat);
    fb    = fold(lon);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_side[0].valid <= 1'b0;
    end else if (en) begin
      c_side[0] <= d_side[QW];
    end
    if (en) begin
      c_a[0] <= fa;
      c_b[0] <= fb;
    end
  end

  for (genvar g = 0; g < NC; g++) begin : g_cordic
    uvs_cordic_cell #(.K(g)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .side_in(c_side[g]), .a_in(c_a[g]), .b_in(c_b[g]),
      .side_out(c_side[g+1]), .a_out(c_a[g+1]), .b_out(c_b[g+1])
    );
  end

  function automatic logic signed [31:0] finish(input logic signed [32:0] v,
                                                input logic flip);
    logic signed [32:0] c;
    logic signed [32:0] n;
    if (v > ONE_Q30) c = ONE_Q30;
    else if (v < -ONE_Q30) c = -ONE_Q30;
    else c = v;
    n = flip ? -c : c;
    return n[31:0];
  endfunction

  side_t              k_side;
  logic signed [31:0] k_cl, k_sl, k_co, k_so;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_side.valid <= 1'b0;
    end else if (en) begin
      k_side <= c_side[NC];
    end
    if (en) begin
      k_cl <= finish(c_a[NC].x, c_a[NC].flip);
      k_sl <= finish(c_a[NC].y, c_a[NC].flip);
      k_co <= finish(c_b[NC].x, c_b[NC].flip);
      k_so <= finish(c_b[NC].y, c_b[NC].flip);
    end
  end

  side_t              m1_side;
  logic signed [32:0] m1_xy, m1_lz;
  logic signed [15:0] m1_nx, m1_ny, m1_nz;
  logic signed [31:0] m1_co, m1_so;
  logic signed [63:0] p_xy, p_lz, p_nx, p_ny, q_xy, q_lz, q_nx, q_ny;
  logic signed [32:0] nz_sum;

  always_comb begin
    p_xy   = $signed({1'b0, sphere_radius}) * k_cl;
    p_lz   = $signed({1'b0, sphere_radius}) * k_sl;
    p_nx   = k_cl * k_co;
    p_ny   = k_cl * k_so;
    q_xy   = (p_xy + RND29) >>> 30;
    q_lz   = (p_lz + RND29) >>> 30;
    q_nx   = (p_nx + RND45) >>> 46;
    q_ny   = (p_ny + RND45) >>> 46;
    nz_sum = ($signed({k_sl[31], k_sl}) + 33'sd32768) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_side.valid <= 1'b0;
    end else if (en) begin
      m1_side <= k_side;
    end
    if (en) begin
      m1_xy <= q_xy[32:0];
      m1_lz <= q_lz[32:0];
      m1_nx <= q_nx[15:0];
      m1_ny <= q_ny[15:0];
      m1_nz <= nz_sum[15:0];
      m1_co <= k_co;
      m1_so <= k_so;
    end
  end

  side_t              m2_side;
  logic signed [33:0] m2_x, m2_y;
  logic signed [32:0] m2_lz;
  logic signed [15:0] m2_nx, m2_ny, m2_nz;
  logic signed [64:0] p_x, p_y, q_x, q_y;

  always_comb begin
    p_x = m1_xy * m1_co;
    p_y = m1_xy * m1_so;
    q_x = (p_x + RND29W) >>> 30;
    q_y = (p_y + RND29W) >>> 30;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_side.valid <= 1'b0;
    end else if (en) begin
      m2_side <= m1_side;
    end
    if (en) begin
      m2_x  <= q_x[33:0];
      m2_y  <= q_y[33:0];
      m2_lz <= m1_lz;
      m2_nx <= m1_nx;
      m2_ny <= m1_ny;
      m2_nz <= m1_nz;
    end
  end

  logic signed [31:0] px, py, pz;

  always_comb begin
    px = sat35($signed({m2_x[33], m2_x}) + $signed({{3{center_x[31]}}, center_x}));
    py = sat35($signed({m2_y[33], m2_y}) + $signed({{3{center_y[31]}}, center_y}));
    pz = sat35($signed({{2{m2_lz[32]}}, m2_lz}) + $signed({{3{center_z[31]}}, center_z}));
  end

  uvs_emit u_emit (
    .clk(clk), .rst(rst),
    .side_in(m2_side),
    .px_in(px), .py_in(py), .pz_in(pz),
    .nx_in(m2_nx), .ny_in(m2_ny), .nz_in(m2_nz),
    .take(take), .busy(busy),
    .out_stall(out_stall), .out_valid(out_valid), .kind(kind),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
    .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
    .last(last)
  );

`ifndef SYNTHESIS
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ERR |-> last)
    else $error("error word without last flag");

  a_tri_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_TRI |-> norm_x == 16'sd0 && pos_x == 32'sd0)
    else $error("triangle word carries vertex data");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    busy |-> in_stall)
    else $error("input taken while serializer holds words");
`endif

endmodule
